FILE: src/dioc_pkg.sv
// Shared types, constants and calendar helpers for the date interval overlap check.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dioc_pkg;

   localparam int DURATION_BITS_DEF = 16;
   localparam int YEAR_W = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_IN_W = 6;
   localparam int DAY_OFS_W = 5;
   // largest day number: 4095*365 + 334 + 30 fits in 21 bits
   localparam int DAY_W = 21;
   localparam int MSTART_W = 9;

   localparam logic [YEAR_W-1:0] MIN_YEAR = YEAR_W'(1901);
   localparam logic [DAY_W-1:0] DAYS_PER_YEAR = DAY_W'(365);
   localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DAYS,
      ST_CMP,
      ST_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic calc_days;
      logic compare;
   } cmd_type;

   // length of a month with no leap years, month already in 1..12
   function automatic logic [DAY_IN_W-1:0] month_length(input logic [MONTH_W-1:0] m);
      logic [DAY_IN_W-1:0] len;
      unique case (m)
         MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_IN_W'(30);
         MONTH_W'(2): len = DAY_IN_W'(28);
         default: len = DAY_IN_W'(31);
      endcase
      return len;
   endfunction

   // days before the first of the month, month already in 1..12
   function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] ofs;
      unique case (m)
         MONTH_W'(2): ofs = MSTART_W'(31);
         MONTH_W'(3): ofs = MSTART_W'(59);
         MONTH_W'(4): ofs = MSTART_W'(90);
         MONTH_W'(5): ofs = MSTART_W'(120);
         MONTH_W'(6): ofs = MSTART_W'(151);
         MONTH_W'(7): ofs = MSTART_W'(181);
         MONTH_W'(8): ofs = MSTART_W'(212);
         MONTH_W'(9): ofs = MSTART_W'(243);
         MONTH_W'(10): ofs = MSTART_W'(273);
         MONTH_W'(11): ofs = MSTART_W'(304);
         MONTH_W'(12): ofs = MSTART_W'(334);
         default: ofs = MSTART_W'(0);
      endcase
      return ofs;
   endfunction

endpackage
`default_nettype wire

FILE: src/dioc_ctrl.sv
// Controller state machine for the date interval overlap check.
// Depends on dioc_pkg for the state and command types.
`timescale 1ns / 1ps
`default_nettype none
module dioc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output dioc_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   dioc_pkg::state_type state_ff, state_in;

   // advance through the fixed sequence of steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dioc_pkg::ST_IDLE: begin
            if (start) state_in = dioc_pkg::ST_DAYS;
         end
         dioc_pkg::ST_DAYS: state_in = dioc_pkg::ST_CMP;
         dioc_pkg::ST_CMP:  state_in = dioc_pkg::ST_RESP;
         dioc_pkg::ST_RESP: state_in = dioc_pkg::ST_IDLE;
         default:           state_in = dioc_pkg::ST_IDLE;
      endcase
   end

   // decode commands and handshake outputs
   always_comb begin
      cmd.load      = (state_ff == dioc_pkg::ST_IDLE) && start;
      cmd.calc_days = (state_ff == dioc_pkg::ST_DAYS);
      cmd.compare   = (state_ff == dioc_pkg::ST_CMP);
      busy          = (state_ff != dioc_pkg::ST_IDLE);
      rsp_valid     = (state_ff == dioc_pkg::ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dioc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/dioc_datapath.sv
// Datapath: clamps both dates, forms linear day numbers and compares the gap
// against the duration. Depends on dioc_pkg for widths and calendar tables.
`timescale 1ns / 1ps
`default_nettype none
module dioc_datapath #(
   parameter int DURATION_BITS = dioc_pkg::DURATION_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire dioc_pkg::cmd_type                    cmd,
   input  wire logic [dioc_pkg::YEAR_W-1:0]          first_year,
   input  wire logic [dioc_pkg::MONTH_W-1:0]         first_month,
   input  wire logic [dioc_pkg::DAY_IN_W-1:0]        first_day,
   input  wire logic [dioc_pkg::YEAR_W-1:0]          second_year,
   input  wire logic [dioc_pkg::MONTH_W-1:0]         second_month,
   input  wire logic [dioc_pkg::DAY_IN_W-1:0]        second_day,
   input  wire logic [DURATION_BITS-1:0]             duration,
   output logic                                      overlap
);

   localparam int CMP_W = (DURATION_BITS > dioc_pkg::DAY_W) ? DURATION_BITS : dioc_pkg::DAY_W;

   typedef struct packed {
      logic [dioc_pkg::YEAR_W-1:0]    year;
      logic [dioc_pkg::MONTH_W-1:0]   month;
      logic [dioc_pkg::DAY_OFS_W-1:0] day_ofs;
   } date_type;

   // clamp year, month and day into range
   function automatic date_type clamp_date(
      input logic [dioc_pkg::YEAR_W-1:0]   y,
      input logic [dioc_pkg::MONTH_W-1:0]  m,
      input logic [dioc_pkg::DAY_IN_W-1:0] d
   );
      date_type                        res;
      logic [dioc_pkg::MONTH_W-1:0]    mc;
      logic [dioc_pkg::DAY_IN_W-1:0]   len;
      logic [dioc_pkg::DAY_IN_W-1:0]   dc;
      res.year = (y < dioc_pkg::MIN_YEAR) ? dioc_pkg::MIN_YEAR : y;
      priority if (m > dioc_pkg::MONTH_LAST) mc = dioc_pkg::MONTH_LAST;
      else if (m < dioc_pkg::MONTH_FIRST) mc = dioc_pkg::MONTH_FIRST;
      else mc = m;
      len = dioc_pkg::month_length(mc);
      priority if (d > len) dc = len;
      else if (d == '0) dc = dioc_pkg::DAY_IN_W'(1);
      else dc = d;
      res.month = mc;
      res.day_ofs = dioc_pkg::DAY_OFS_W'(dc - dioc_pkg::DAY_IN_W'(1));
      return res;
   endfunction

   function automatic logic [dioc_pkg::DAY_W-1:0] day_number(input date_type dt);
      return dioc_pkg::DAY_W'(dt.year) * dioc_pkg::DAYS_PER_YEAR
           + dioc_pkg::DAY_W'(dioc_pkg::month_start(dt.month))
           + dioc_pkg::DAY_W'(dt.day_ofs);
   endfunction

   date_type                        date_a_ff, date_b_ff;
   logic [DURATION_BITS-1:0]        dur_ff;
   logic [dioc_pkg::DAY_W-1:0]      num_a_ff, num_b_ff;
   logic [dioc_pkg::DAY_W-1:0]      gap;
   logic                            overlap_ff;

   // capture clamped dates on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         date_a_ff <= clamp_date(first_year, first_month, first_day);
         date_b_ff <= clamp_date(second_year, second_month, second_day);
         dur_ff    <= duration;
      end
   end

   // form linear day numbers
   always_ff @(posedge clock) begin
      if (cmd.calc_days) begin
         num_a_ff <= day_number(date_a_ff);
         num_b_ff <= day_number(date_b_ff);
      end
   end

   // the stepped earlier date passes the later one when duration exceeds the gap
   assign gap = (num_a_ff < num_b_ff) ? (num_b_ff - num_a_ff) : (num_a_ff - num_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         overlap_ff <= CMP_W'(dur_ff) > CMP_W'(gap);
      end
   end

   assign overlap = overlap_ff;

endmodule
`default_nettype wire

FILE: src/date_interval_overlap_check_unit.sv
// Date interval overlap check: two clamped calendar dates (no leap years) and a
// duration; reports whether the earlier date plus the duration passes the later one.
// After the accepting edge the controller steps through ST_DAYS, ST_CMP and ST_RESP; busy is
// high in all three and rsp_valid in ST_RESP, so a new word is taken only once back in idle:
// the accept cycle clamps, then the day-number, compare and response steps follow. The receiver cannot stall.
// Reset (synchronous, active high) returns the controller to idle; no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module date_interval_overlap_check_unit #(
   parameter int DURATION_BITS = dioc_pkg::DURATION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [dioc_pkg::YEAR_W-1:0]       req_first_year,
   input  wire logic [dioc_pkg::MONTH_W-1:0]      req_first_month,
   input  wire logic [dioc_pkg::DAY_IN_W-1:0]     req_first_day,
   input  wire logic [dioc_pkg::YEAR_W-1:0]       req_second_year,
   input  wire logic [dioc_pkg::MONTH_W-1:0]      req_second_month,
   input  wire logic [dioc_pkg::DAY_IN_W-1:0]     req_second_day,
   input  wire logic [DURATION_BITS-1:0]          req_duration,
   output logic                                   rsp_valid,
   output logic                                   rsp_overlap
);

   dioc_pkg::cmd_type cmd;

   // sequence the steps
   dioc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // clamp, count days, compare
   dioc_datapath #(
      .DURATION_BITS (DURATION_BITS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .first_year   (req_first_year),
      .first_month  (req_first_month),
      .first_day    (req_first_day),
      .second_year  (req_second_year),
      .second_month (req_second_month),
      .second_day   (req_second_day),
      .duration     (req_duration),
      .overlap      (rsp_overlap)
   );

endmodule
`default_nettype wire
